// ===== design/cau_pkg.sv =====
// ----------------------------------------------------------------------------
// cau_pkg
// Shared codes and defaults for the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

	localparam int DATA_WIDTH_DEF = 16;
	localparam int FRAC_BITS_DEF  = 8;

	// operation codes
	typedef enum logic [2:0] {
		ACT_ADD = 3'd0,
		ACT_SUB = 3'd1,
		ACT_MUL = 3'd2,
		ACT_DIV = 3'd3,
		ACT_MAG = 3'd4
	} action_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_DIVZ = 2'd1,
		ST_SAT  = 2'd2
	} status_t;

endpackage

// ===== design/complex_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Pipelined complex ALU in signed fixed point: add, subtract, multiply,
// divide and magnitude, with rounding, saturation and status.
// ----------------------------------------------------------------------------
// Usage:
//   request channel: req_valid / req_stall with action, a_re, a_im, b_re,
//   b_im. A request is taken on a rising edge with req_valid high and
//   req_stall low.
//   response channel: rsp_valid / rsp_stall with res_re, res_im, status.
//   Each request gives exactly one response, in order.
//   The pipeline has one stage of multipliers, one of sums, one of
//   rounding and divide setup, then DATA_WIDTH + 1 restoring-divide
//   stages (the square root runs in the first DATA_WIDTH of them), and
//   the output register. Throughput is one request per cycle while no
//   response is stalled; every operation takes the same path.
//   When the receiver stalls a valid response, the whole pipeline holds and
//   req_stall rises in the same cycle; nothing is dropped or repeated.
//   Reset (arst_n low) empties the pipeline; payload registers keep junk
//   behind cleared valid bits.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit #(
	parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  logic [2:0]                   action,
	input  logic signed [DATA_WIDTH-1:0] a_re,
	input  logic signed [DATA_WIDTH-1:0] a_im,
	input  logic signed [DATA_WIDTH-1:0] b_re,
	input  logic signed [DATA_WIDTH-1:0] b_im,
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output logic signed [DATA_WIDTH-1:0] res_re,
	output logic signed [DATA_WIDTH-1:0] res_im,
	output logic [1:0]                   status
);

	localparam int W  = DATA_WIDTH;
	localparam int F  = FRAC_BITS;
	localparam int PW = 2 * W;
	localparam int Q  = W + 1;
	localparam int NW = PW + F + 2;
	localparam int CW = NW + Q;
	localparam int MW = PW + 2;
	localparam logic [PW:0] RND = (F == 0) ? '0 : ((PW+1)'(1) << ((F == 0) ? 0 : F - 1));
	localparam logic [MW-1:0] LIM = MW'(1) << (W - 1);

	typedef struct packed {
		logic [2:0]    act;
		logic          neg_re;
		logic          neg_im;
		logic [PW:0]   mag_re;
		logic [PW:0]   mag_im;
		logic          divz;
		logic          ovf_re;
		logic          ovf_im;
		logic [PW-1:0] rem_re;
		logic [PW-1:0] rem_im;
		logic [Q-1:0]  lo_re;
		logic [Q-1:0]  lo_im;
		logic [Q-1:0]  q_re;
		logic [Q-1:0]  q_im;
		logic [PW-1:0] den;
		logic [PW-1:0] sx;
		logic [W-1:0]  root;
		logic [W+1:0]  srem;
	} stage_t;

	logic adv;

	// whole pipeline holds while a response waits
	assign adv       = !(rsp_valid && rsp_stall);
	assign req_stall = rsp_valid && rsp_stall;

	// stage 1: products and plain sums
	logic                 v_s1;
	logic [2:0]           act_s1;
	logic signed [PW-1:0] p_rr_s1, p_ii_s1, p_ir_s1, p_ri_s1;
	logic signed [PW-1:0] p_aa_s1, p_a2_s1, p_bb_s1, p_b2_s1;
	logic signed [W:0]    add_re_s1, add_im_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			act_s1  <= action;
			p_rr_s1 <= a_re * b_re;
			p_ii_s1 <= a_im * b_im;
			p_ir_s1 <= a_im * b_re;
			p_ri_s1 <= a_re * b_im;
			p_aa_s1 <= a_re * a_re;
			p_a2_s1 <= a_im * a_im;
			p_bb_s1 <= b_re * b_re;
			p_b2_s1 <= b_im * b_im;
			if (action == cau_pkg::ACT_SUB) begin
				add_re_s1 <= (W+1)'(a_re) - (W+1)'(b_re);
				add_im_s1 <= (W+1)'(a_im) - (W+1)'(b_im);
			end else begin
				add_re_s1 <= (W+1)'(a_re) + (W+1)'(b_re);
				add_im_s1 <= (W+1)'(a_im) + (W+1)'(b_im);
			end
		end
	end

	// stage 2: sums of products, split into sign and magnitude
	logic signed [PW:0] sre, sim, sden, ssq;
	logic               v_s2;
	logic [2:0]         act_s2;
	logic               neg_re_s2, neg_im_s2;
	logic [PW:0]        mag_re_s2, mag_im_s2;
	logic [PW-1:0]      den_s2, sqx_s2;

	always_comb begin
		sre = '0;
		sim = '0;
		case (act_s1)
			cau_pkg::ACT_ADD, cau_pkg::ACT_SUB: begin
				sre = (PW+1)'(add_re_s1);
				sim = (PW+1)'(add_im_s1);
			end
			cau_pkg::ACT_MUL: begin
				sre = (PW+1)'(p_rr_s1) - (PW+1)'(p_ii_s1);
				sim = (PW+1)'(p_ir_s1) + (PW+1)'(p_ri_s1);
			end
			cau_pkg::ACT_DIV: begin
				sre = (PW+1)'(p_rr_s1) + (PW+1)'(p_ii_s1);
				sim = (PW+1)'(p_ir_s1) - (PW+1)'(p_ri_s1);
			end
			default: begin
				sre = '0;
				sim = '0;
			end
		endcase
		sden = (PW+1)'(p_bb_s1) + (PW+1)'(p_b2_s1);
		ssq  = (PW+1)'(p_aa_s1) + (PW+1)'(p_a2_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			act_s2    <= act_s1;
			neg_re_s2 <= sre[PW];
			neg_im_s2 <= sim[PW];
			mag_re_s2 <= sre[PW] ? -sre : sre;
			mag_im_s2 <= sim[PW] ? -sim : sim;
			den_s2    <= sden[PW-1:0];
			sqx_s2    <= ssq[PW-1:0];
		end
	end

	// stage 3: product rounding, divide setup
	stage_t        setup;
	logic [NW-1:0] n_re, n_im;

	always_comb begin
		n_re = (NW'(mag_re_s2) << F) + NW'(den_s2 >> 1);
		n_im = (NW'(mag_im_s2) << F) + NW'(den_s2 >> 1);
		setup        = '0;
		setup.act    = act_s2;
		setup.neg_re = neg_re_s2;
		setup.neg_im = neg_im_s2;
		if (act_s2 == cau_pkg::ACT_MUL) begin
			setup.mag_re = (mag_re_s2 + RND) >> F;
			setup.mag_im = (mag_im_s2 + RND) >> F;
		end else begin
			setup.mag_re = mag_re_s2;
			setup.mag_im = mag_im_s2;
		end
		setup.divz   = (den_s2 == '0);
		setup.ovf_re = CW'(n_re) >= (CW'(den_s2) << Q);
		setup.ovf_im = CW'(n_im) >= (CW'(den_s2) << Q);
		setup.rem_re = PW'(n_re >> Q);
		setup.rem_im = PW'(n_im >> Q);
		setup.lo_re  = n_re[Q-1:0];
		setup.lo_im  = n_im[Q-1:0];
		setup.den    = den_s2;
		setup.sx     = sqx_s2;
	end

	stage_t step_s [0:Q];
	logic   vld_s  [0:Q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			step_s[0] <= setup;
		end
	end

	// divide stages: one quotient bit per stage for both parts,
	// square root digit in the first W stages
	for (genvar k = 0; k < Q; k++) begin : g_step
		stage_t      nxt;
		logic [PW:0] t_re, t_im;
		logic [W+2:0] t_sq, trial;

		always_comb begin
			nxt   = step_s[k];
			t_re  = {step_s[k].rem_re, step_s[k].lo_re[Q-1]};
			t_im  = {step_s[k].rem_im, step_s[k].lo_im[Q-1]};
			t_sq  = {step_s[k].srem[W:0], step_s[k].sx[PW-1:PW-2]};
			trial = (W+3)'({step_s[k].root, 2'b01});
			nxt.lo_re = step_s[k].lo_re << 1;
			nxt.lo_im = step_s[k].lo_im << 1;
			if (t_re >= {1'b0, step_s[k].den}) begin
				nxt.rem_re = PW'(t_re - {1'b0, step_s[k].den});
				nxt.q_re   = {step_s[k].q_re[Q-2:0], 1'b1};
			end else begin
				nxt.rem_re = PW'(t_re);
				nxt.q_re   = {step_s[k].q_re[Q-2:0], 1'b0};
			end
			if (t_im >= {1'b0, step_s[k].den}) begin
				nxt.rem_im = PW'(t_im - {1'b0, step_s[k].den});
				nxt.q_im   = {step_s[k].q_im[Q-2:0], 1'b1};
			end else begin
				nxt.rem_im = PW'(t_im);
				nxt.q_im   = {step_s[k].q_im[Q-2:0], 1'b0};
			end
			if (k < W) begin
				nxt.sx = step_s[k].sx << 2;
				if (t_sq >= trial) begin
					nxt.srem = (W+2)'(t_sq - trial);
					nxt.root = {step_s[k].root[W-2:0], 1'b1};
				end else begin
					nxt.srem = (W+2)'(t_sq);
					nxt.root = {step_s[k].root[W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (adv) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				step_s[k+1] <= nxt;
			end
		end
	end

	// final select, clamp and status
	stage_t        fs;
	logic [MW-1:0] m_re, m_im, c_re, c_im;
	logic          ng_re, ng_im, sat_re, sat_im;
	logic [W-1:0]  o_re, o_im;
	logic [1:0]    o_st;

	always_comb begin
		fs    = step_s[Q];
		ng_re = fs.neg_re;
		ng_im = fs.neg_im;
		m_re  = MW'(fs.mag_re);
		m_im  = MW'(fs.mag_im);
		case (fs.act)
			cau_pkg::ACT_DIV: begin
				m_re = fs.ovf_re ? '1 : MW'(fs.q_re);
				m_im = fs.ovf_im ? '1 : MW'(fs.q_im);
			end
			cau_pkg::ACT_MAG: begin
				ng_re = 1'b0;
				ng_im = 1'b0;
				m_re  = MW'(fs.root) + MW'(MW'(fs.srem) > MW'(fs.root));
				m_im  = '0;
			end
			default: begin
				m_re = MW'(fs.mag_re);
				m_im = MW'(fs.mag_im);
			end
		endcase
		sat_re = ng_re ? (m_re > LIM) : (m_re > LIM - 1'b1);
		sat_im = ng_im ? (m_im > LIM) : (m_im > LIM - 1'b1);
		c_re   = sat_re ? (ng_re ? LIM : LIM - 1'b1) : m_re;
		c_im   = sat_im ? (ng_im ? LIM : LIM - 1'b1) : m_im;
		o_re   = ng_re ? W'(-c_re) : W'(c_re);
		o_im   = ng_im ? W'(-c_im) : W'(c_im);
		o_st   = (sat_re || sat_im) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
		if (fs.act == cau_pkg::ACT_DIV && fs.divz) begin
			o_re = '0;
			o_im = '0;
			o_st = cau_pkg::ST_DIVZ;
		end else if (fs.act > cau_pkg::ACT_MAG) begin
			o_re = '0;
			o_im = '0;
			o_st = cau_pkg::ST_OK;
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (adv) begin
			rsp_valid <= vld_s[Q];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_re <= o_re;
			res_im <= o_im;
			status <= o_st;
		end
	end

	// checks
	a_no_bad_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> status != 2'd3)
		else $error("undefined status code");

	a_divz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == cau_pkg::ST_DIVZ |-> res_re == '0 && res_im == '0)
		else $error("divide by zero with nonzero result");

	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> rsp_valid && rsp_stall)
		else $error("request stalled without a waiting response");

	a_hold_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_s[Q]))
		else $error("pipeline moved while stalled");

endmodule
